// ===== src/scrambled_operand_field_codec_defines.svh =====
// ----------------------------------------------------------------------------
// Scrambled operand field codec: assertion macros
// Shared property forms for the codec's checks, clocked on i_clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef SCRAMBLED_OPERAND_FIELD_CODEC_DEFINES_SVH
`define SCRAMBLED_OPERAND_FIELD_CODEC_DEFINES_SVH

// Same-cycle implication
`define SOCF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("socf check failed");

// Next-cycle implication
`define SOCF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("socf check failed");

`endif

// ===== src/socf_pkg.sv =====
// ----------------------------------------------------------------------------
// socf_pkg
// Widths, codes and the byte-0 scramble shared by the codec modules.
// ----------------------------------------------------------------------------
`default_nettype none

package socf_pkg;

    localparam int MAX_BYTES = 3;
    localparam int BYTE_W    = 8;
    localparam int WORD_W    = MAX_BYTES * BYTE_W;
    localparam int FIELD_W   = WORD_W + 1;
    localparam int CNT_W     = $clog2(WORD_W + 1);
    localparam int LEN_W     = 2;

    localparam logic OP_DECODE = 1'b0;
    localparam logic OP_ENCODE = 1'b1;

    // bits untouched by the scramble, and the data-byte MSB flip
    localparam logic [BYTE_W-1:0] PERM_KEEP = 8'hCA;
    localparam logic [BYTE_W-1:0] FLIP_MSB  = 8'h80;

    typedef logic [WORD_W-1:0]             t_word;
    typedef logic [FIELD_W-1:0]            t_field;
    typedef logic [WORD_W-1:0][CNT_W-1:0]  t_rank_vec;

    // swap bits 4/5 and 0/2; self-inverse
    function automatic logic [BYTE_W-1:0] permute_first(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] n;
        n    = b & PERM_KEEP;
        n[5] = b[4];
        n[4] = b[5];
        n[2] = b[0];
        n[0] = b[2];
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== src/socf_rank.sv =====
// ----------------------------------------------------------------------------
// socf_rank
// Effective mask (length gated, byte 0 unscrambled) and bit ranks within it.
// ----------------------------------------------------------------------------
`default_nettype none

module socf_rank (
    input  wire logic [socf_pkg::LEN_W-1:0] i_length,
    input  wire socf_pkg::t_word            i_field_mask,
    output socf_pkg::t_word                 o_eff_mask,
    output socf_pkg::t_rank_vec             o_rank,
    output logic [socf_pkg::CNT_W-1:0]      o_count
);
    import socf_pkg::*;

    t_word m;
    t_word lm;

    always_comb begin
        m = '0;
        for (int i = 0; i < MAX_BYTES; i++) begin
            if (i < int'(i_length)) begin
                if (i == 0) begin
                    m[WORD_W-1 -: BYTE_W] = permute_first(i_field_mask[WORD_W-1 -: BYTE_W]);
                end else begin
                    m[WORD_W-1-BYTE_W*i -: BYTE_W] = i_field_mask[WORD_W-1-BYTE_W*i -: BYTE_W];
                end
            end
        end
    end

    // rank = number of mask bits below each position
    always_comb begin
        o_rank = '0;
        lm     = '0;
        for (int p = 0; p < WORD_W; p++) begin
            lm        = {WORD_W{1'b1}} >> (WORD_W - p);
            o_rank[p] = CNT_W'($countones(m & lm));
        end
    end

    assign o_eff_mask = m;
    assign o_count    = CNT_W'($countones(m));

endmodule

`default_nettype wire

// ===== src/socf_gather.sv =====
// ----------------------------------------------------------------------------
// socf_gather
// Decode: packs the masked data bits into the field, optional sign extension.
// ----------------------------------------------------------------------------
`default_nettype none

module socf_gather (
    input  wire socf_pkg::t_word            i_instr_bytes,
    input  wire socf_pkg::t_word            i_eff_mask,
    input  wire socf_pkg::t_rank_vec        i_rank,
    input  wire logic [socf_pkg::CNT_W-1:0] i_count,
    input  wire logic                       i_is_signed,
    output socf_pkg::t_field                o_field_value
);
    import socf_pkg::*;

    t_word  d;
    t_word  acc;
    t_field ext;
    logic   sign_bit;

    always_comb begin
        d = i_instr_bytes;
        d[WORD_W-1 -: BYTE_W] = permute_first(i_instr_bytes[WORD_W-1 -: BYTE_W]) ^ FLIP_MSB;
    end

    always_comb begin
        acc = '0;
        for (int p = 0; p < WORD_W; p++) begin
            if (i_eff_mask[p]) begin
                acc[i_rank[p]] = d[p];
            end
        end
    end

    assign sign_bit = (i_count != '0) ? acc[CNT_W'(i_count - 1'b1)] : 1'b0;
    assign ext      = {FIELD_W{1'b1}} << i_count;

    assign o_field_value = (i_is_signed && sign_bit) ? ({1'b0, acc} | ext) : {1'b0, acc};

endmodule

`default_nettype wire

// ===== src/socf_scatter.sv =====
// ----------------------------------------------------------------------------
// socf_scatter
// Encode: spreads the value's low bits over the mask and ORs into the bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module socf_scatter (
    input  wire socf_pkg::t_word     i_instr_bytes,
    input  wire socf_pkg::t_word     i_eff_mask,
    input  wire socf_pkg::t_rank_vec i_rank,
    input  wire socf_pkg::t_field    i_value,
    output socf_pkg::t_word          o_out_bytes
);
    import socf_pkg::*;

    t_word dep;
    t_word dep_s;

    always_comb begin
        dep = '0;
        for (int p = 0; p < WORD_W; p++) begin
            dep[p] = i_eff_mask[p] & i_value[i_rank[p]];
        end
    end

    // byte 0 goes back to scrambled order
    always_comb begin
        dep_s = dep;
        dep_s[WORD_W-1 -: BYTE_W] = permute_first(dep[WORD_W-1 -: BYTE_W]);
    end

    assign o_out_bytes = i_instr_bytes | dep_s;

endmodule

`default_nettype wire

// ===== src/scrambled_operand_field_codec.sv =====
// ----------------------------------------------------------------------------
// scrambled_operand_field_codec
// Operand field extract/deposit for instructions with a scrambled first byte.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  input   | in        | i_in_valid / o_in_ready    | op, length, field_mask,
//          |           |                            | is_signed, instr_bytes, value
//  result  | out       | o_out_valid / i_out_ready  | field_value, out_bytes
//
//  One item per cycle unless results stall; input, then result register.
//  Rank, gather and scatter logic sit between the two registers.
//  A stalled result holds; the input register keeps taking items while the
//  result register is free or being drained.
//  Synchronous active-low reset clears both valid flags only.
// ----------------------------------------------------------------------------
`default_nettype none
`include "scrambled_operand_field_codec_defines.svh"

module scrambled_operand_field_codec (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic                        i_op,
    input  wire logic [socf_pkg::LEN_W-1:0]  i_length,
    input  wire logic [socf_pkg::WORD_W-1:0] i_field_mask,
    input  wire logic                        i_is_signed,
    input  wire logic [socf_pkg::WORD_W-1:0] i_instr_bytes,
    input  wire logic signed [socf_pkg::FIELD_W-1:0] i_value,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic signed [socf_pkg::FIELD_W-1:0] o_field_value,
    output logic [socf_pkg::WORD_W-1:0]      o_out_bytes
);
    import socf_pkg::*;

    logic              r_s1_valid, n_s1_valid;
    logic              r_s1_op;
    logic [LEN_W-1:0]  r_s1_len;
    t_word             r_s1_mask;
    logic              r_s1_sgn;
    t_word             r_s1_bytes;
    t_field            r_s1_value;

    logic              r_out_valid, n_out_valid;
    t_field            r_field_value;
    t_word             r_out_bytes;

    logic              in_acc;
    logic              s1_advance;
    logic              s1_dec_move;
    logic              s1_enc_move;

    t_word             eff_mask;
    t_rank_vec         rank;
    logic [CNT_W-1:0]  count;
    t_field            dec_field;
    t_word             enc_bytes;

    assign s1_advance = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || s1_advance;
    assign in_acc     = i_in_valid && o_in_ready;

    assign s1_dec_move = r_s1_valid && s1_advance && (r_s1_op == OP_DECODE);
    assign s1_enc_move = r_s1_valid && s1_advance && (r_s1_op == OP_ENCODE);

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_acc) begin
            n_s1_valid = 1'b1;
        end else if (s1_advance) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = s1_advance ? r_s1_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op    <= i_op;
            r_s1_len   <= i_length;
            r_s1_mask  <= i_field_mask;
            r_s1_sgn   <= i_is_signed;
            r_s1_bytes <= i_instr_bytes;
            r_s1_value <= $unsigned(i_value);
        end
    end

    socf_rank u_rank (
        .i_length     (r_s1_len),
        .i_field_mask (r_s1_mask),
        .o_eff_mask   (eff_mask),
        .o_rank       (rank),
        .o_count      (count)
    );

    socf_gather u_gather (
        .i_instr_bytes (r_s1_bytes),
        .i_eff_mask    (eff_mask),
        .i_rank        (rank),
        .i_count       (count),
        .i_is_signed   (r_s1_sgn),
        .o_field_value (dec_field)
    );

    socf_scatter u_scatter (
        .i_instr_bytes (r_s1_bytes),
        .i_eff_mask    (eff_mask),
        .i_rank        (rank),
        .i_value       (r_s1_value),
        .o_out_bytes   (enc_bytes)
    );

    always_ff @(posedge i_clk) begin
        if (s1_advance && r_s1_valid) begin
            if (r_s1_op == OP_ENCODE) begin
                r_field_value <= '0;
                r_out_bytes   <= enc_bytes;
            end else begin
                r_field_value <= dec_field;
                r_out_bytes   <= r_s1_bytes;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_field_value = $signed(r_field_value);
    assign o_out_bytes   = r_out_bytes;

    // an item held in stage 1 is never dropped while the result side stalls
    `SOCF_ASSERT_NEXT(a_s1_kept, r_s1_valid && !s1_advance, r_s1_valid)
    // decode passes the bytes through untouched
    `SOCF_ASSERT_NEXT(a_dec_bytes, s1_dec_move, o_out_bytes == $past(r_s1_bytes))
    // encode reports a zero field
    `SOCF_ASSERT_NEXT(a_enc_zero, s1_enc_move, o_field_value == '0)
    // encode only sets bits, never clears them
    `SOCF_ASSERT_NEXT(a_enc_or, s1_enc_move, (o_out_bytes & $past(r_s1_bytes)) == $past(r_s1_bytes))
    // result valid only appears after stage 1 held an item
    `SOCF_ASSERT_NEXT(a_out_src, !r_out_valid && !r_s1_valid, !r_out_valid)

endmodule

`default_nettype wire
